/* rtl/csb_pkg.sv */
// Shared types, constants and helpers of the cross stencil blur filter.
package csb_pkg;

	localparam int DEF_MAX_WIDTH   = 512;
	localparam int DEF_MAX_HEIGHT  = 512;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam int CHAN_W      = 16;
	localparam int DIM_W       = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int                RESET_FRAME_WIDTH   = 480;
	localparam int                RESET_FRAME_HEIGHT  = 360;
	localparam logic [CHAN_W-1:0] RESET_CENTER_WEIGHT = 16'd34079;
	localparam logic [CHAN_W-1:0] RESET_SIDE_WEIGHT   = 16'd7864;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_CENTER_WEIGHT,
		REG_SIDE_WEIGHT
	} cfg_reg_t;

	// Element 0 is red, 1 green, 2 blue.
	typedef logic [2:0][CHAN_W-1:0] rgb_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
		logic              flush;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic              border;
		logic              last;
	} pix_out_t;

	// One column of the line store: the previous row and the row before it.
	typedef struct packed {
		rgb_t newer;
		rgb_t older;
	} line_word_t;

	// Neighborhood of one output pixel, handed from front to back.
	typedef struct packed {
		rgb_t ctr;
		rgb_t lft;
		rgb_t rgt;
		rgb_t up;
		rgb_t dn;
		logic border;
		logic last;
	} stencil_t;

	function automatic int clamp_dim(input int v, input int hi);
		int r;
		r = v;
		if (r < 3) r = 3;
		if (r > hi) r = hi;
		return r;
	endfunction

endpackage

/* rtl/csb_stream_if.sv */
// Valid/ready stream channel carrying one word per handshake.
interface csb_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/csb_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module csb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/csb_front.sv */
// Front end: accepts pixels, tracks position, keeps the line store, builds neighborhoods.
module csb_front #(
	parameter int MAX_WIDTH  = csb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = csb_pkg::DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CW-1:0]     w_last,
	input  logic [RW-1:0]     h_rows,
	input  logic              restart,
	csb_stream_if.sink        pixel,
	input  logic              q_full,
	output logic              push,
	output csb_pkg::stencil_t entry
);
	import csb_pkg::*;

	localparam int WORD_W = $bits(line_word_t);

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	line_word_t        mid_q;
	rgb_t              left_q;
	rgb_t              pix;
	line_word_t        rd_word;
	line_word_t        wr_word;
	logic [WORD_W-1:0] rd_data;
	logic              accept;
	logic              col_end;
	logic [CW:0]       col_p2;
	logic [CW:0]       w_cnt;
	logic [CW:0]       ra_wide;
	logic [CW-1:0]     rd_addr;

	assign pixel.ready = !q_full;
	assign accept      = pixel.valid && !q_full;
	assign pix         = pixel.data.flush ? '0 :
		{pixel.data.blue_in, pixel.data.green_in, pixel.data.red_in};
	assign col_end     = col_q == w_last;

	// Fetch two columns ahead, wrapping into the next row.
	assign col_p2  = {1'b0, col_q} + (CW + 1)'(2);
	assign w_cnt   = {1'b0, w_last} + (CW + 1)'(1);
	assign ra_wide = (col_p2 >= w_cnt) ? col_p2 - w_cnt : col_p2;
	assign rd_addr = ra_wide[CW-1:0];

	assign rd_word       = line_word_t'(rd_data);
	assign wr_word.newer = pix;
	assign wr_word.older = mid_q.newer;

	csb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(WORD_W'(wr_word)),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Slide the window by one column per accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= mid_q.newer;
			mid_q  <= rd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= (row_q == h_rows) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Row zero only fills the store.
	assign push = accept && (row_q != '0);

	always_comb begin
		entry.ctr    = mid_q.newer;
		entry.lft    = left_q;
		entry.rgt    = rd_word.newer;
		entry.up     = mid_q.older;
		entry.dn     = pix;
		entry.border = (row_q == RW'(1)) || (row_q == h_rows) || (col_q == '0) || col_end;
		entry.last   = (row_q == h_rows) && col_end;
	end

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last)
		else $error("column counter beyond frame width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_rows)
		else $error("row counter beyond flush row");
endmodule

/* rtl/csb_queue.sv */
// Short FIFO of neighborhoods between front and back.
module csb_queue #(
	parameter int DEPTH = csb_pkg::DEF_QUEUE_DEPTH,
	localparam int AW = $clog2(DEPTH),
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csb_pkg::stencil_t push_data,
	output logic              full,
	input  logic              pop,
	output csb_pkg::stencil_t pop_data,
	output logic              not_empty
);
	import csb_pkg::*;

	stencil_t      mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full      = count_q == NW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + NW'(1))
		else $error("queue fill count lost a push");
endmodule

/* rtl/csb_back.sv */
// Back end: weighted five-point sum per channel, round down, saturate, border pass-through, output register.
module csb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [csb_pkg::CHAN_W-1:0] center_weight,
	input  logic [csb_pkg::CHAN_W-1:0] side_weight,
	input  logic                       avail,
	input  csb_pkg::stencil_t          entry,
	output logic                       pop,
	csb_stream_if.source               filtered
);
	import csb_pkg::*;

	// stage 1: center product and side sum
	logic             v_s1;
	rgb_t             ctr_s1;
	logic [2:0][31:0] cprod_s1;
	logic [2:0][17:0] ssum_s1;
	logic             border_s1;
	logic             last_s1;
	// stage 2: side product
	logic             v_s2;
	rgb_t             ctr_s2;
	logic [2:0][31:0] cprod_s2;
	logic [2:0][33:0] sprod_s2;
	logic             border_s2;
	logic             last_s2;
	// output register
	logic             vld_q;
	pix_out_t         res_q;

	logic             ld1, ld2, ld3;
	logic [2:0][34:0] total;
	rgb_t             blur;
	rgb_t             chan_out;

	assign ld3 = !vld_q || filtered.ready;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign pop = avail && ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (ld1) v_s1 <= avail;
			if (ld2) v_s2 <= v_s1;
			if (ld3) vld_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			ctr_s1    <= entry.ctr;
			border_s1 <= entry.border;
			last_s1   <= entry.last;
			for (int k = 0; k < 3; k++) begin
				cprod_s1[k] <= {16'b0, entry.ctr[k]} * {16'b0, center_weight};
				ssum_s1[k]  <= {2'b0, entry.lft[k]} + {2'b0, entry.rgt[k]}
					+ {2'b0, entry.up[k]} + {2'b0, entry.dn[k]};
			end
		end
		if (ld2) begin
			ctr_s2    <= ctr_s1;
			border_s2 <= border_s1;
			last_s2   <= last_s1;
			cprod_s2  <= cprod_s1;
			for (int k = 0; k < 3; k++) begin
				sprod_s2[k] <= {16'b0, ssum_s1[k]} * {18'b0, side_weight};
			end
		end
		if (ld3) begin
			res_q.red_out   <= chan_out[0];
			res_q.green_out <= chan_out[1];
			res_q.blue_out  <= chan_out[2];
			res_q.border    <= border_s2;
			res_q.last      <= last_s2;
		end
	end

	// Drop the 16 fraction bits, clip at full scale; border pixels pass.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			total[k] = {3'b0, cprod_s2[k]} + {1'b0, sprod_s2[k]};
			blur[k]  = (|total[k][34:32]) ? '1 : total[k][31:16];
		end
		chan_out = border_s2 ? ctr_s2 : blur;
	end

	assign filtered.valid = vld_q;
	assign filtered.data  = res_q;

	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped neighborhood missing from stage 1");
endmodule

/* rtl/cross_stencil_blur_filter_unit.sv */
// Top level of the five-point cross stencil blur filter for raster RGB streams.
//
//  channel    dir  word                                   accepted when
//  ---------  ---  -------------------------------------  ------------------------
//  pixel      in   red_in green_in blue_in (Q4.12) flush  pixel.valid & pixel.ready
//  filtered   out  red_out green_out blue_out border last filtered.valid & .ready
//  cfg        in   cfg_index, cfg_data                    cfg_wr_en
//
//  One pixel word per clock, sustained while the queue has room; the line store
//  takes one write and one read per word, which sets that rate. A result is offered
//  once the pixel that completes its neighborhood has passed the queue slot, both
//  multiply stages and the output register, later when older words wait in the
//  queue; results lag input by one row, emptied by a flush row.
//  Reset clears counters, pipeline valids and the queue; the line store needs no
//  clearing pass: entries read before a frame writes them reach only border pixels.
//  A stalled output fills the pipe and the queue, then pixel.ready drops.
module cross_stencil_blur_filter_unit #(
	parameter int MAX_WIDTH   = csb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = csb_pkg::DEF_MAX_HEIGHT,
	parameter int QUEUE_DEPTH = csb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [csb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data,
	csb_stream_if.sink                     pixel,
	csb_stream_if.source                   filtered
);
	import csb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	// Geometry is held already clamped: last column index and number of rows.
	localparam int W_RESET = clamp_dim(RESET_FRAME_WIDTH, MAX_WIDTH);
	localparam int H_RESET = clamp_dim(RESET_FRAME_HEIGHT, MAX_HEIGHT);

	cfg_reg_t          cfg_reg;
	logic [CW-1:0]     w_last_q;
	logic [RW-1:0]     h_rows_q;
	logic [CHAN_W-1:0] center_weight_q;
	logic [CHAN_W-1:0] side_weight_q;
	logic              restart;

	logic              push;
	stencil_t          push_entry;
	logic              q_full;
	logic              pop;
	stencil_t          pop_entry;
	logic              q_avail;

	assign cfg_reg = cfg_reg_t'(cfg_index);

	// Register writes. Clamp frame dimensions to 3..MAX once, here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q        <= CW'(W_RESET - 1);
			h_rows_q        <= RW'(H_RESET);
			center_weight_q <= RESET_CENTER_WEIGHT;
			side_weight_q   <= RESET_SIDE_WEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_reg)
				REG_FRAME_WIDTH: begin
					w_last_q <= CW'(clamp_dim(int'(cfg_data[DIM_W-1:0]), MAX_WIDTH) - 1);
				end
				REG_FRAME_HEIGHT: begin
					h_rows_q <= RW'(clamp_dim(int'(cfg_data[DIM_W-1:0]), MAX_HEIGHT));
				end
				REG_CENTER_WEIGHT: begin
					center_weight_q <= cfg_data;
				end
				REG_SIDE_WEIGHT: begin
					side_weight_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// A new geometry starts a new frame: restart position in the same cycle.
	always_comb begin
		restart = 1'b0;
		if (cfg_wr_en) begin
			case (cfg_reg)
				REG_FRAME_WIDTH, REG_FRAME_HEIGHT: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	// Front: position tracking, line store, neighborhood assembly.
	csb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.w_last (w_last_q),
		.h_rows (h_rows_q),
		.restart(restart),
		.pixel  (pixel),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	// Queue decouples front acceptance from back stalls.
	csb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_entry),
		.not_empty(q_avail)
	);

	// Back: multiply, accumulate, saturate, hold result until taken.
	csb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.center_weight(center_weight_q),
		.side_weight  (side_weight_q),
		.avail        (q_avail),
		.entry        (pop_entry),
		.pop          (pop),
		.filtered     (filtered)
	);
endmodule

/* dv/tb_cross_stencil_blur_filter_unit.sv */
// Self-checking testbench for the cross stencil blur filter top level.
`timescale 1ns / 100ps

module tb_cross_stencil_blur_filter_unit;
	import csb_pkg::*;

	localparam int unsigned MAX_W         = DEF_MAX_WIDTH;
	localparam int unsigned MAX_H         = DEF_MAX_HEIGHT;
	// Cycles to let the pipe empty after the last expected word: queue, two
	// multiply stages and output register, plus margin.
	localparam int unsigned SETTLE_CYCLES = 12;
	// Longest stretch with no word moving on either channel before giving up.
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned MAX_REPORTS   = 100;

	typedef enum logic {PACE_STEADY, PACE_JITTER} pace_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	csb_stream_if #(.item_t(pix_in_t))  pixel_ch ();
	csb_stream_if #(.item_t(pix_out_t)) result_ch ();

	// Mirror of the filter: register copies, position and the two-row line store.
	logic [DIM_W-1:0]  geo_width;
	logic [DIM_W-1:0]  geo_height;
	logic [CHAN_W-1:0] wt_center;
	logic [CHAN_W-1:0] wt_side;
	int unsigned       col_pos;
	int unsigned       row_pos;
	rgb_t              row_mem [0:2*MAX_W-1];

	pix_out_t          blurred_q [$];
	int unsigned       mismatch_count;
	int unsigned       pixels_sent;
	int unsigned       quiet_cycles;
	int unsigned       stall_left;
	pace_t             tx_pace;
	pace_t             rx_pace;
	logic              rx_hold;

	cross_stencil_blur_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.filtered  (result_ch)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Mostly back to back, often a short gap, rarely a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Bias toward the ends of the Q4.12 range so saturation and zero show up often.
	function automatic logic [CHAN_W-1:0] rand_chan();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return CHAN_W'($urandom);
	endfunction

	function automatic pix_in_t mk_pixel(input logic [CHAN_W-1:0] red, green, blue,
			input logic flush);
		pix_in_t p;
		p.red_in   = red;
		p.green_in = green;
		p.blue_in  = blue;
		p.flush    = flush;
		return p;
	endfunction

	function automatic pix_in_t rand_pixel(input int unsigned flush_pct);
		return mk_pixel(rand_chan(), rand_chan(), rand_chan(),
			$urandom_range(0, 99) < flush_pct);
	endfunction

	// Geometry value with junk in the unused upper bits; mostly small frames.
	function automatic logic [CFG_DATA_W-1:0] pick_dim(input int unsigned wide_hi);
		int unsigned r;
		logic [DIM_W-1:0] v;
		r = $urandom_range(0, 19);
		if (r < 14)
			v = DIM_W'($urandom_range(3, 10));
		else if (r < 18)
			v = DIM_W'($urandom_range(11, wide_hi));
		else
			v = DIM_W'($urandom_range(0, 2));
		return {6'($urandom), v};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_weight();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return CFG_DATA_W'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	// Q4.12 times Q0.16 summed to Q4.28, floor to Q4.12, saturate.
	function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] ctr, lf, rt, up, dn);
		logic [47:0] acc;
		acc = 48'(ctr) * 48'(wt_center)
			+ (48'(lf) + 48'(rt) + 48'(up) + 48'(dn)) * 48'(wt_side);
		acc = acc >> 16;
		return (acc > 48'hFFFF) ? 16'hFFFF : acc[CHAN_W-1:0];
	endfunction

	// Advance the mirror by one accepted pixel word and queue the word it releases.
	task automatic predict_pixel(input pix_in_t word);
		int unsigned w, h, c, r, orow, cur, abv, k;
		rgb_t px, ctr, outv;
		pix_out_t res;
		logic rim;
		w = fit_dim(geo_width, MAX_W);
		h = fit_dim(geo_height, MAX_H);
		c = col_pos;
		r = row_pos;
		if (c >= w || r > h) begin
			c = 0;
			r = 0;
		end
		// Flush words count as black, whatever their colour fields hold.
		px = word.flush ? '0 : {word.blue_in, word.green_in, word.red_in};
		if (r >= 1) begin
			orow = r - 1;
			cur  = (orow & 1) * MAX_W;
			abv  = (r & 1) * MAX_W;
			ctr  = row_mem[cur + c];
			rim  = (orow == 0) || (orow == h - 1) || (c == 0) || (c == w - 1);
			for (k = 0; k < 3; k++) begin
				if (rim)
					outv[k] = ctr[k];
				else
					outv[k] = blend(ctr[k], row_mem[cur + c - 1][k], row_mem[cur + c + 1][k],
						row_mem[abv + c][k], px[k]);
			end
			res.red_out   = outv[0];
			res.green_out = outv[1];
			res.blue_out  = outv[2];
			res.border    = rim;
			res.last      = (orow == h - 1) && (c == w - 1);
			blurred_q.push_back(res);
		end
		row_mem[(r & 1) * MAX_W + c] = px;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r > h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [CHAN_W-1:0] want, got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
	endtask

	task automatic compare_blurred(input pix_out_t got);
		pix_out_t want;
		if (blurred_q.size() == 0) begin
			flag_mismatch("filtered word with none pending", '0, got.red_out);
			return;
		end
		want = blurred_q.pop_front();
		if (got.red_out !== want.red_out)
			flag_mismatch("red_out", want.red_out, got.red_out);
		if (got.green_out !== want.green_out)
			flag_mismatch("green_out", want.green_out, got.green_out);
		if (got.blue_out !== want.blue_out)
			flag_mismatch("blue_out", want.blue_out, got.blue_out);
		if (got.border !== want.border)
			flag_mismatch("border", CHAN_W'(want.border), CHAN_W'(got.border));
		if (got.last !== want.last)
			flag_mismatch("last", CHAN_W'(want.last), CHAN_W'(got.last));
	endtask

	// Sample both channels at the edge: predict on pixel words, check filtered
	// words, and stop the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_ch.valid && pixel_ch.ready)
				predict_pixel(pixel_ch.data);
			if (result_ch.valid && result_ch.ready)
				compare_blurred(result_ch.data);
			if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: hold off while a test asks for it, otherwise take words freely
	// or with random stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (rx_hold) begin
			result_ch.ready <= 1'b0;
		end else if (rx_pace == PACE_STEADY) begin
			result_ch.ready <= 1'b1;
		end else begin
			if (stall_left == 0) stall_left = gap_len();
			if (stall_left == 0) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offer one pixel word and return at the edge that takes it. Valid stays up
	// so the next word can follow back to back; drop it only ahead of a gap.
	task automatic send_pixel(input pix_in_t word);
		int unsigned gap;
		gap = (tx_pace == PACE_STEADY) ? 0 : gap_len();
		if (gap > 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.data  <= word;
		do @(posedge clk); while (!pixel_ch.ready);
		pixels_sent++;
	endtask

	// Stop offering, wait for every pending filtered word, then let the pipe settle.
	task automatic drain();
		pixel_ch.valid <= 1'b0;
		while (blurred_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register and mirror it; a geometry write restarts the frame.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				geo_width = val[DIM_W-1:0];
				col_pos   = 0;
				row_pos   = 0;
			end
			REG_FRAME_HEIGHT: begin
				geo_height = val[DIM_W-1:0];
				col_pos    = 0;
				row_pos    = 0;
			end
			REG_CENTER_WEIGHT: wt_center = val;
			REG_SIDE_WEIGHT:   wt_side   = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// One frame in raster order followed by its row of padding words.
	task automatic send_frame(input int unsigned w, h, flush_pct, tint_pct);
		int unsigned i;
		for (i = 0; i < w * h; i++)
			send_pixel(rand_pixel(flush_pct));
		for (i = 0; i < w; i++)
			send_pixel(rand_pixel(100 - tint_pct));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Run two rows and a bit at reset geometry and weights, then abandon the
	// frame; the next geometry write has to restart it.
	task automatic test_reset_config();
		int unsigned i;
		tx_pace = PACE_JITTER;
		rx_pace <= PACE_JITTER;
		for (i = 0; i < 2 * RESET_FRAME_WIDTH + 40; i++)
			send_pixel(rand_pixel(2));
		drain();
	endtask

	// Two 3x3 frames: full weights on white saturate the middle pixel; then a
	// zero center weight, a flush word inside the frame and a colour word in the
	// padding row.
	task automatic test_directed_corners();
		int unsigned i;
		tx_pace = PACE_STEADY;
		rx_pace <= PACE_JITTER;
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		write_reg(REG_CENTER_WEIGHT, 16'hFFFF);
		write_reg(REG_SIDE_WEIGHT, 16'hFFFF);
		for (i = 0; i < 9; i++)
			send_pixel((i == 0) ? mk_pixel('0, '0, '0, 1'b0) : mk_pixel('1, '1, '1, 1'b0));
		for (i = 0; i < 3; i++)
			send_pixel(mk_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b1));
		drain();

		write_reg(REG_CENTER_WEIGHT, 16'h0000);
		tx_pace = PACE_JITTER;
		send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
		send_pixel(mk_pixel(16'h1000, 16'h1000, 16'h1000, 1'b0));
		send_pixel(mk_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0));
		send_pixel(mk_pixel(16'h0001, 16'h0001, 16'h0001, 1'b0));
		send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		// Right neighbour of the middle pixel arrives as a flush word: black.
		send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		send_pixel(mk_pixel(16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0));
		// Padding row led by a colour word, which must act as padding.
		send_pixel(mk_pixel(16'hABCD, 16'hABCD, 16'hABCD, 1'b0));
		send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		drain();
	endtask

	// Clamp the width register from above and below and the height from below: a
	// full-width short frame and a narrow full-height one.
	task automatic test_size_extremes();
		tx_pace = PACE_JITTER;
		rx_pace <= PACE_JITTER;
		write_reg(REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(REG_FRAME_HEIGHT, 16'd0);
		write_reg(REG_SIDE_WEIGHT, 16'h0000);
		send_frame(fit_dim(geo_width, MAX_W), fit_dim(geo_height, MAX_H), 2, 10);
		drain();
		write_reg(REG_FRAME_WIDTH, 16'd2);
		write_reg(REG_FRAME_HEIGHT, 16'd512);
		write_reg(REG_CENTER_WEIGHT, pick_weight());
		write_reg(REG_SIDE_WEIGHT, pick_weight());
		send_frame(fit_dim(geo_width, MAX_W), fit_dim(geo_height, MAX_H), 2, 10);
		drain();
	endtask

	// Hold the receiver off for a long stretch while pixels keep coming, so the
	// queue fills and pixel.ready drops.
	task automatic test_backpressure();
		write_reg(REG_FRAME_WIDTH, 16'd8);
		write_reg(REG_FRAME_HEIGHT, 16'd5);
		tx_pace = PACE_STEADY;
		rx_pace <= PACE_STEADY;
		rx_hold <= 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		send_frame(8, 5, 0, 0);
		drain();
	endtask

	// Stop sending partway into a frame until every pending word is out, then
	// finish the frame.
	task automatic test_pause_mid_frame();
		int unsigned i;
		write_reg(REG_FRAME_WIDTH, 16'd6);
		write_reg(REG_FRAME_HEIGHT, 16'd4);
		tx_pace = PACE_JITTER;
		rx_pace <= PACE_JITTER;
		for (i = 0; i < 6 * 5; i++) begin
			if (i == 15) drain();
			send_pixel(rand_pixel(5));
		end
		drain();
	endtask

	// Mostly well-formed frames with random content and settings; some frames are
	// cut short and some bursts are noise, and both force a geometry rewrite.
	task automatic test_random_frames();
		int unsigned goal, w, h, kind, n, i;
		logic need_geo;
		goal     = pixels_sent + 550;
		need_geo = 1'b1;
		while (pixels_sent < goal) begin
			if (need_geo || $urandom_range(0, 3) == 0) begin
				drain();
				if (need_geo || $urandom_range(0, 1) == 0) begin
					write_reg(REG_FRAME_WIDTH, pick_dim(40));
					write_reg(REG_FRAME_HEIGHT, pick_dim(16));
				end
				if ($urandom_range(0, 1) == 0) write_reg(REG_CENTER_WEIGHT, pick_weight());
				if ($urandom_range(0, 1) == 0) write_reg(REG_SIDE_WEIGHT, pick_weight());
				need_geo = 1'b0;
			end
			tx_pace = ($urandom_range(0, 3) == 0) ? PACE_STEADY : PACE_JITTER;
			rx_pace <= ($urandom_range(0, 3) == 0) ? PACE_STEADY : PACE_JITTER;
			w    = fit_dim(geo_width, MAX_W);
			h    = fit_dim(geo_height, MAX_H);
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				send_frame(w, h, 3, 10);
			end else if (kind == 8) begin
				n = $urandom_range(1, w * h);
				for (i = 0; i < n; i++) send_pixel(rand_pixel(3));
				need_geo = 1'b1;
			end else begin
				n = $urandom_range(1, 20);
				for (i = 0; i < n; i++) send_pixel(rand_pixel(50));
				need_geo = 1'b1;
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_data        = '0;
		pixel_ch.valid  = 1'b0;
		pixel_ch.data   = '0;
		result_ch.ready = 1'b0;
		rx_hold         = 1'b0;
		rx_pace         = PACE_STEADY;
		tx_pace         = PACE_STEADY;
		stall_left      = 0;
		quiet_cycles    = 0;
		mismatch_count  = 0;
		pixels_sent     = 0;
		geo_width       = RESET_FRAME_WIDTH;
		geo_height      = RESET_FRAME_HEIGHT;
		wt_center       = RESET_CENTER_WEIGHT;
		wt_side         = RESET_SIDE_WEIGHT;
		col_pos         = 0;
		row_pos         = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_reset_config();
		test_directed_corners();
		test_size_extremes();
		test_backpressure();
		test_pause_mid_frame();
		test_random_frames();

		if (blurred_q.size() != 0)
			flag_mismatch("filtered words never arrived", '0, CHAN_W'(blurred_q.size()));
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
